/* rtl/bmprle_pkg.sv */
// Shared types, constants and codes of the BMP RLE pixel decoder.
`default_nettype none

package bmprle_pkg;

    // Fixed sizes of the datapath
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);
    localparam int COLOR_W    = 24;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_W      = 13;
    localparam int ROW_W      = 12;
    localparam int X_W        = 12;
    localparam int CNT_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int REQ_W      = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // Item kinds carried in tuser
    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PAL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd2;

    // Escape codes that follow a zero command byte
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        PH_FINISHED,
        PH_COMMAND,
        PH_RUN_COLOR,
        PH_ESCAPE,
        PH_DELTA_X,
        PH_DELTA_Y,
        PH_ABS_DATA,
        PH_ABS_PAD
    } t_phase;

    // Effective configuration seen by the parser
    typedef struct packed {
        logic             four;
        logic [DIM_W-1:0] w_eff;
        logic [DIM_W-1:0] h_eff;
    } t_cfg;

    // One run description without colors
    typedef struct packed {
        logic [X_W-1:0]   x_start;
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] count;
        logic             done;
    } t_run;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [COLOR_W-1:0] color;
    } t_pal_wr;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr_a;
        logic [PAL_AW-1:0] addr_b;
    } t_pal_rd;

endpackage

`default_nettype wire

/* rtl/bmprle_palette.sv */
// Palette memory with one write port, two registered read ports and valid bits.
`default_nettype none

module bmprle_palette (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bmprle_pkg::t_pal_wr               i_wr,
    input  wire bmprle_pkg::t_pal_rd               i_rd,
    output logic [bmprle_pkg::COLOR_W-1:0]         o_color_a,
    output logic [bmprle_pkg::COLOR_W-1:0]         o_color_b
);

    logic [bmprle_pkg::COLOR_W-1:0]   r_mem [bmprle_pkg::PAL_DEPTH];
    logic [bmprle_pkg::PAL_DEPTH-1:0] r_valid;
    logic [bmprle_pkg::COLOR_W-1:0]   r_data_a;
    logic [bmprle_pkg::COLOR_W-1:0]   r_data_b;
    logic                             r_va;
    logic                             r_vb;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.color;
        end
        if (i_rd.en) begin
            r_data_a <= r_mem[i_rd.addr_a];
            r_data_b <= r_mem[i_rd.addr_b];
            r_va     <= r_valid[i_rd.addr_a];
            r_vb     <= r_valid[i_rd.addr_b];
        end
    end

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Entries never written read as black
    assign o_color_a = r_va ? r_data_a : '0;
    assign o_color_b = r_vb ? r_data_b : '0;

endmodule

`default_nettype wire

/* rtl/bmprle_parser.sv */
// Byte stream parser: decode state, run clipping and palette access requests.
`default_nettype none

module bmprle_parser (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bmprle_pkg::t_cfg                  i_cfg,
    input  wire logic                              i_accept,
    input  wire logic [bmprle_pkg::REQ_W-1:0]      i_req,
    input  wire logic [bmprle_pkg::PAL_AW-1:0]     i_pal_index,
    input  wire logic [bmprle_pkg::COLOR_W-1:0]    i_pal_color,
    input  wire logic [bmprle_pkg::BYTE_W-1:0]     i_data_byte,
    output bmprle_pkg::t_pal_wr                    o_pal_wr,
    output bmprle_pkg::t_pal_rd                    o_pal_rd,
    output logic                                   o_res_valid,
    output bmprle_pkg::t_run                       o_res
);

    bmprle_pkg::t_phase                r_phase, n_phase;
    logic [bmprle_pkg::DIM_W-1:0]      r_column, n_column;
    logic [bmprle_pkg::ROW_W-1:0]      r_row, n_row;
    logic [bmprle_pkg::CNT_W-1:0]      r_pending, n_pending;
    logic                              r_parity, n_parity;
    logic [bmprle_pkg::BYTE_W-1:0]     r_dx, n_dx;

    logic                              is_start;
    logic                              is_byte;
    logic [bmprle_pkg::DIM_W-1:0]      room;
    logic [bmprle_pkg::CNT_W-1:0]      run_n;
    logic [bmprle_pkg::CNT_W-1:0]      abs_want;
    logic [bmprle_pkg::CNT_W-1:0]      abs_take;
    logic [bmprle_pkg::CNT_W-1:0]      abs_n;
    logic [bmprle_pkg::CNT_W-1:0]      abs_left;
    logic [bmprle_pkg::DIM_W-1:0]      delta_sum;
    logic [bmprle_pkg::DIM_W-1:0]      delta_col;
    logic                              delta_off;
    logic [bmprle_pkg::BYTE_W-1:0]     b;

    assign b        = i_data_byte;
    assign is_start = i_accept && (i_req == bmprle_pkg::REQ_START);
    assign is_byte  = i_accept && (i_req == bmprle_pkg::REQ_BYTE);

    // Pixels left on the current row
    assign room  = (r_column < i_cfg.w_eff) ? (i_cfg.w_eff - r_column) : '0;
    assign run_n = ({5'b0, r_pending} < room) ? r_pending : room[bmprle_pkg::CNT_W-1:0];

    // Absolute run: one or two pixels per byte
    assign abs_want = (i_cfg.four && (r_pending >= 8'd2)) ? 8'd2 : 8'd1;
    assign abs_take = (abs_want > r_pending) ? r_pending : abs_want;
    assign abs_n    = ({5'b0, abs_take} < room) ? abs_take : room[bmprle_pkg::CNT_W-1:0];
    assign abs_left = r_pending - abs_take;

    // Delta move, saturated at the row width
    assign delta_sum = r_column + {5'b0, r_dx};
    assign delta_col = (delta_sum > i_cfg.w_eff) ? i_cfg.w_eff : delta_sum;
    assign delta_off = r_row < {4'b0, b};

    // Palette access
    assign o_pal_wr.en    = i_accept && (i_req == bmprle_pkg::REQ_PAL);
    assign o_pal_wr.addr  = i_pal_index;
    assign o_pal_wr.color = i_pal_color;
    assign o_pal_rd.en     = is_byte;
    assign o_pal_rd.addr_a = i_cfg.four ? {4'b0, b[7:4]} : b;
    assign o_pal_rd.addr_b = i_cfg.four ? {4'b0, b[3:0]} : b;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (is_start) begin
            n_phase = bmprle_pkg::PH_COMMAND;
        end else if (is_byte) begin
            unique case (r_phase)
                bmprle_pkg::PH_FINISHED: begin
                    n_phase = bmprle_pkg::PH_FINISHED;
                end
                bmprle_pkg::PH_COMMAND: begin
                    n_phase = (b == '0) ? bmprle_pkg::PH_ESCAPE : bmprle_pkg::PH_RUN_COLOR;
                end
                bmprle_pkg::PH_RUN_COLOR: begin
                    n_phase = bmprle_pkg::PH_COMMAND;
                end
                bmprle_pkg::PH_ESCAPE: begin
                    if (b == bmprle_pkg::ESC_EOB) begin
                        n_phase = bmprle_pkg::PH_FINISHED;
                    end else if (b == bmprle_pkg::ESC_EOL) begin
                        n_phase = (r_row == '0) ? bmprle_pkg::PH_FINISHED
                                                : bmprle_pkg::PH_COMMAND;
                    end else if (b == bmprle_pkg::ESC_DELTA) begin
                        n_phase = bmprle_pkg::PH_DELTA_X;
                    end else begin
                        n_phase = bmprle_pkg::PH_ABS_DATA;
                    end
                end
                bmprle_pkg::PH_DELTA_X: begin
                    n_phase = bmprle_pkg::PH_DELTA_Y;
                end
                bmprle_pkg::PH_DELTA_Y: begin
                    n_phase = delta_off ? bmprle_pkg::PH_FINISHED : bmprle_pkg::PH_COMMAND;
                end
                bmprle_pkg::PH_ABS_DATA: begin
                    if (abs_left == '0) begin
                        n_phase = (!r_parity) ? bmprle_pkg::PH_ABS_PAD
                                              : bmprle_pkg::PH_COMMAND;
                    end
                end
                bmprle_pkg::PH_ABS_PAD: begin
                    n_phase = bmprle_pkg::PH_COMMAND;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Position update and result item
    always_comb begin
        n_column    = r_column;
        n_row       = r_row;
        n_pending   = r_pending;
        n_parity    = r_parity;
        n_dx        = r_dx;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.row   = r_row;
        o_res.x_start = r_column[bmprle_pkg::X_W-1:0];
        if (is_start) begin
            n_column  = '0;
            n_row     = bmprle_pkg::ROW_W'(i_cfg.h_eff - 13'd1);
            n_pending = '0;
            n_parity  = 1'b0;
            n_dx      = '0;
        end else if (is_byte) begin
            unique case (r_phase)
                bmprle_pkg::PH_FINISHED: begin
                    n_column = r_column;
                end
                bmprle_pkg::PH_COMMAND: begin
                    if (b != '0) begin
                        n_pending = b;
                    end
                end
                bmprle_pkg::PH_RUN_COLOR: begin
                    o_res_valid = 1'b1;
                    o_res.count = run_n;
                    n_column    = r_column + {5'b0, run_n};
                    n_pending   = '0;
                end
                bmprle_pkg::PH_ESCAPE: begin
                    if (b == bmprle_pkg::ESC_EOB) begin
                        o_res_valid = 1'b1;
                        o_res.done  = 1'b1;
                    end else if (b == bmprle_pkg::ESC_EOL) begin
                        n_column = '0;
                        if (r_row == '0) begin
                            o_res_valid   = 1'b1;
                            o_res.done    = 1'b1;
                            o_res.x_start = '0;
                        end else begin
                            n_row = r_row - 12'd1;
                        end
                    end else if (b != bmprle_pkg::ESC_DELTA) begin
                        n_pending = b;
                        n_parity  = 1'b0;
                    end
                end
                bmprle_pkg::PH_DELTA_X: begin
                    n_dx = b;
                end
                bmprle_pkg::PH_DELTA_Y: begin
                    n_column = delta_col;
                    n_dx     = '0;
                    if (delta_off) begin
                        o_res_valid   = 1'b1;
                        o_res.done    = 1'b1;
                        o_res.x_start = delta_col[bmprle_pkg::X_W-1:0];
                    end else begin
                        n_row = r_row - {4'b0, b};
                    end
                end
                bmprle_pkg::PH_ABS_DATA: begin
                    o_res_valid = 1'b1;
                    o_res.count = abs_n;
                    n_column    = r_column + {5'b0, abs_n};
                    n_pending   = abs_left;
                    n_parity    = ~r_parity;
                end
                bmprle_pkg::PH_ABS_PAD: begin
                    n_parity = 1'b0;
                end
                default: begin
                    n_column = r_column;
                end
            endcase
        end
    end

    // Hold decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bmprle_pkg::PH_FINISHED;
            r_column  <= '0;
            r_row     <= '0;
            r_pending <= '0;
            r_parity  <= 1'b0;
            r_dx      <= '0;
        end else begin
            r_phase   <= n_phase;
            r_column  <= n_column;
            r_row     <= n_row;
            r_pending <= n_pending;
            r_parity  <= n_parity;
            r_dx      <= n_dx;
        end
    end

endmodule

`default_nettype wire

/* rtl/bmprle_out.sv */
// Result pipeline: palette-read stage and output register with color merge.
`default_nettype none

module bmprle_out (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_res_valid,
    input  wire bmprle_pkg::t_run                   i_res,
    input  wire logic [bmprle_pkg::COLOR_W-1:0]     i_color_a,
    input  wire logic [bmprle_pkg::COLOR_W-1:0]     i_color_b,
    input  wire logic                               i_m_ready,
    output logic                                    o_in_ready,
    output logic                                    o_m_valid,
    output logic [bmprle_pkg::OUT_DATA_W-1:0]       o_m_data,
    output logic                                    o_m_last
);

    logic                            r_s1_valid;
    bmprle_pkg::t_run                r_s1;
    logic                            r_out_valid;
    bmprle_pkg::t_run                r_out;
    logic [bmprle_pkg::COLOR_W-1:0]  r_c1;
    logic [bmprle_pkg::COLOR_W-1:0]  r_c2;
    logic                            out_free;
    logic                            s1_move;

    assign out_free   = !r_out_valid || i_m_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;

    // Hold the run while the palette read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_s1 <= i_res;
        end
    end

    // Advance into the output register, dropping colors on the done item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= r_s1;
            r_c1  <= r_s1.done ? '0 : i_color_a;
            r_c2  <= r_s1.done ? '0 : i_color_b;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_last  = r_out.done;
    assign o_m_data  = {r_c2, r_c1, r_out.count, r_out.row, r_out.x_start};

endmodule

`default_nettype wire

/* rtl/bmp_rle_pixel_decoder.sv */
// Top level of the BMP RLE8/RLE4 pixel decoder: config registers and datapath.
//
// Usage:
//   Configure over the APB port while idle: pixel depth mode (0x0), image width
//   (0x4) and image height (0x8); pready is always high and reads return values.
//   Input items on s_axis: tuser selects start, palette write or stream byte.
//   A start item places the position at column 0 of the bottom stored row.
//   Result items on m_axis describe one run each: start column, row, clipped
//   count and two alternating colors; tlast marks the end-of-bitmap item.
//   Throughput: one input item per cycle while s_axis_tready is high. A result
//   leaves through the registered palette read stage and then the output
//   register; the palette RAM read port forms the first of these registers.
//   A stalled receiver holds the output register; one more result item still
//   enters the read stage, after which s_axis_tready drops until the output
//   moves. Items that give no result are taken whenever the read stage is
//   free or draining.
//   Reset clears the registers to mode 0, width 1, height 1, waits for a start
//   item and marks all palette entries as black at once (valid bits, no sweep).
`default_nettype none

module bmp_rle_pixel_decoder (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // APB configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bmprle_pkg::APB_AW-1:0]        paddr,
    input  wire logic [bmprle_pkg::APB_DW-1:0]        pwdata,
    output logic [bmprle_pkg::APB_DW-1:0]             prdata,
    output logic                                      pready,
    // Input items
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [7:0] palette_index, [31:8] palette_color, [39:32] data_byte
    input  wire logic [bmprle_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  wire logic [bmprle_pkg::REQ_W-1:0]         s_axis_tuser,
    // Result items
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [11:0] x_start, [23:12] row, [31:24] pixel_count,
    // [55:32] color_first, [79:56] color_second
    output logic [bmprle_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // image_done
    output logic                                      m_axis_tlast
);

    logic                              r_mode;
    logic [bmprle_pkg::DIM_W-1:0]      r_width;
    logic [bmprle_pkg::DIM_W-1:0]      r_height;
    logic                              cfg_wr;
    logic [1:0]                        reg_idx;
    bmprle_pkg::t_cfg                  cfg;
    logic                              in_accept;
    bmprle_pkg::t_pal_wr               pal_wr;
    bmprle_pkg::t_pal_rd               pal_rd;
    logic [bmprle_pkg::COLOR_W-1:0]    color_a;
    logic [bmprle_pkg::COLOR_W-1:0]    color_b;
    logic                              res_valid;
    bmprle_pkg::t_run                  res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[bmprle_pkg::APB_AW-1:2];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_width  <= 13'd1;
            r_height <= 13'd1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bmprle_pkg::REG_MODE:   r_mode   <= pwdata[0];
                bmprle_pkg::REG_WIDTH:  r_width  <= pwdata[bmprle_pkg::DIM_W-1:0];
                bmprle_pkg::REG_HEIGHT: r_height <= pwdata[bmprle_pkg::DIM_W-1:0];
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            bmprle_pkg::REG_MODE:   prdata = {31'b0, r_mode};
            bmprle_pkg::REG_WIDTH:  prdata = {19'b0, r_width};
            bmprle_pkg::REG_HEIGHT: prdata = {19'b0, r_height};
            default:                prdata = '0;
        endcase
    end

    // Clamp width and height to the supported range
    assign cfg.four  = r_mode;
    assign cfg.w_eff = (r_width > bmprle_pkg::DIM_W'(bmprle_pkg::MAX_WIDTH))
                     ? bmprle_pkg::DIM_W'(bmprle_pkg::MAX_WIDTH) : r_width;
    assign cfg.h_eff = (r_height == '0) ? 13'd1
                     : (r_height > bmprle_pkg::DIM_W'(bmprle_pkg::MAX_HEIGHT))
                     ? bmprle_pkg::DIM_W'(bmprle_pkg::MAX_HEIGHT) : r_height;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    bmprle_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (in_accept),
        .i_req       (s_axis_tuser),
        .i_pal_index (s_axis_tdata[7:0]),
        .i_pal_color (s_axis_tdata[31:8]),
        .i_data_byte (s_axis_tdata[39:32]),
        .o_pal_wr    (pal_wr),
        .o_pal_rd    (pal_rd),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bmprle_palette u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pal_wr),
        .i_rd      (pal_rd),
        .o_color_a (color_a),
        .o_color_b (color_b)
    );

    bmprle_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_color_a   (color_a),
        .i_color_b   (color_b),
        .i_m_ready   (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .o_m_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* rtl/bmprle_checker.sv */
// Port-level checker of the BMP RLE pixel decoder and its bind.
`default_nettype none

module bmprle_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 pready,
    input  wire logic                                 s_axis_tready,
    input  wire logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic [bmprle_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire logic                                 m_axis_tlast
);

    // End-of-bitmap item carries no pixels and no colors
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[79:24] == '0))
        else $error("done item with pixels or colors");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // Reset empties the result path
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Input side is open right after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // Configuration port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind bmp_rle_pixel_decoder bmprle_checker u_bmprle_checker (.*);

`default_nettype wire

/* tb/bmp_rle_run_checker.sv */
// Run checker for the BMP RLE pixel decoder: mirrors its state and compares every run item.
module bmp_rle_run_checker
    import bmprle_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_AW-1:0]     i_paddr,
    input  wire logic [APB_DW-1:0]     i_pwdata,
    input  wire logic                  i_pready,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // [7:0] palette_index, [31:8] palette_color, [39:32] data_byte
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  wire logic [REQ_W-1:0]      i_s_tuser,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // [11:0] x_start, [23:12] row, [31:24] pixel_count,
    // [55:32] color_first, [79:56] color_second
    input  wire logic [OUT_DATA_W-1:0] i_m_tdata,
    // image_done
    input  wire logic                  i_m_tlast,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_runs_checked,
    output int                         o_done_runs
);
    timeunit 1ns;
    timeprecision 1ps;

    // A zero command byte introduces an escape code
    localparam logic [BYTE_W-1:0] ESCAPE_LEAD = 8'd0;

    typedef struct packed {
        logic [X_W-1:0]     x_start;
        logic [ROW_W-1:0]   row;
        logic [CNT_W-1:0]   count;
        logic [COLOR_W-1:0] color_first;
        logic [COLOR_W-1:0] color_second;
        logic               done;
    } run_t;

    // Mirrored configuration
    logic               depth4;
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;

    // Mirrored decode state
    logic [COLOR_W-1:0] palette [PAL_DEPTH];
    t_phase             phase;
    logic [DIM_W-1:0]   column;
    logic [ROW_W-1:0]   cur_row;
    logic [CNT_W-1:0]   run_left;
    logic               abs_parity;
    logic [BYTE_W-1:0]  delta_dx;

    run_t               expected_runs [$];
    run_t               want_run;
    int                 fails;
    int                 runs;
    int                 dones;

    // Queue one run item at the current position
    function automatic void push_run(input int unsigned count, input logic [COLOR_W-1:0] first,
                                     input logic [COLOR_W-1:0] second, input logic done);
        run_t r;
        r.x_start      = column[X_W-1:0];
        r.row          = cur_row;
        r.count        = count[CNT_W-1:0];
        r.color_first  = first;
        r.color_second = second;
        r.done         = done;
        expected_runs.push_back(r);
    endfunction

    // Close the bitmap with a done item
    function automatic void end_bitmap();
        phase = PH_FINISHED;
        push_run(0, '0, '0, 1'b1);
    endfunction

    // Advance the decode state by one accepted item and queue the run it yields
    function automatic void decode_item(input logic [REQ_W-1:0] kind, input logic [7:0] idx,
                                        input logic [COLOR_W-1:0] color,
                                        input logic [BYTE_W-1:0] b);
        int unsigned w;
        int unsigned h;
        int unsigned room;
        int unsigned n;
        int unsigned want;
        int unsigned moved;
        logic [COLOR_W-1:0] hi_color;
        logic [COLOR_W-1:0] lo_color;

        w    = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        room = (column < w) ? w - column : 0;
        if (depth4) begin
            hi_color = palette[{4'h0, b[7:4]}];
            lo_color = palette[{4'h0, b[3:0]}];
        end else begin
            hi_color = palette[b];
            lo_color = hi_color;
        end

        case (kind)
            REQ_START: begin
                if (cfg_height == 0)
                    h = 1;
                else if (cfg_height > MAX_HEIGHT)
                    h = MAX_HEIGHT;
                else
                    h = cfg_height;
                column     = '0;
                cur_row    = h - 1;
                run_left   = '0;
                abs_parity = 1'b0;
                delta_dx   = '0;
                phase      = PH_COMMAND;
            end
            REQ_PAL: palette[idx] = color;
            REQ_BYTE: begin
                case (phase)
                    PH_COMMAND: begin
                        if (b == ESCAPE_LEAD) begin
                            phase = PH_ESCAPE;
                        end else begin
                            run_left = b;
                            phase    = PH_RUN_COLOR;
                        end
                    end
                    PH_RUN_COLOR: begin
                        n = (run_left < room) ? run_left : room;
                        push_run(n, hi_color, lo_color, 1'b0);
                        column   = column + n;
                        run_left = '0;
                        phase    = PH_COMMAND;
                    end
                    PH_ESCAPE: begin
                        if (b == ESC_EOB) begin
                            end_bitmap();
                        end else if (b == ESC_EOL) begin
                            column = '0;
                            if (cur_row == 0) begin
                                end_bitmap();
                            end else begin
                                cur_row = cur_row - 1;
                                phase   = PH_COMMAND;
                            end
                        end else if (b == ESC_DELTA) begin
                            phase = PH_DELTA_X;
                        end else begin
                            run_left   = b;
                            abs_parity = 1'b0;
                            phase      = PH_ABS_DATA;
                        end
                    end
                    PH_DELTA_X: begin
                        delta_dx = b;
                        phase    = PH_DELTA_Y;
                    end
                    PH_DELTA_Y: begin
                        // Column saturates at the width; moving above the top ends the bitmap
                        moved    = column + delta_dx;
                        column   = (moved > w) ? w : moved;
                        delta_dx = '0;
                        if (cur_row < b) begin
                            end_bitmap();
                        end else begin
                            cur_row = cur_row - b;
                            phase   = PH_COMMAND;
                        end
                    end
                    PH_ABS_DATA: begin
                        want = (depth4 && run_left >= 2) ? 2 : 1;
                        if (want > run_left)
                            want = run_left;
                        n = (want < room) ? want : room;
                        push_run(n, hi_color, lo_color, 1'b0);
                        column     = column + n;
                        run_left   = run_left - want;
                        abs_parity = ~abs_parity;
                        if (run_left == 0)
                            phase = abs_parity ? PH_ABS_PAD : PH_COMMAND;
                    end
                    PH_ABS_PAD: begin
                        abs_parity = 1'b0;
                        phase      = PH_COMMAND;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    // Compare one field and count a mismatch
    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fails++;
        end
    endtask

    // Track register writes, check result items, then predict from input items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth4     = 1'b0;
            cfg_width  = 13'd1;
            cfg_height = 13'd1;
            for (int k = 0; k < PAL_DEPTH; k++)
                palette[k] = '0;
            phase      = PH_FINISHED;
            column     = '0;
            cur_row    = '0;
            run_left   = '0;
            abs_parity = 1'b0;
            delta_dx   = '0;
            expected_runs.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_MODE:   depth4     = i_pwdata[0];
                    REG_WIDTH:  cfg_width  = i_pwdata[DIM_W-1:0];
                    REG_HEIGHT: cfg_height = i_pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_runs.size() == 0) begin
                    $error("unexpected run item: tdata 0x%0h, tlast %0b", i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    want_run = expected_runs.pop_front();
                    check_field("x_start", want_run.x_start, i_m_tdata[11:0]);
                    check_field("row", want_run.row, i_m_tdata[23:12]);
                    check_field("pixel_count", want_run.count, i_m_tdata[31:24]);
                    check_field("color_first", want_run.color_first, i_m_tdata[55:32]);
                    check_field("color_second", want_run.color_second, i_m_tdata[79:56]);
                    check_field("image_done", want_run.done, i_m_tlast);
                    runs++;
                    if (want_run.done)
                        dones++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                decode_item(i_s_tuser, i_s_tdata[7:0], i_s_tdata[31:8], i_s_tdata[39:32]);
        end
        o_pending      <= expected_runs.size();
        o_fail_count   <= fails;
        o_runs_checked <= runs;
        o_done_runs    <= dones;
    end

endmodule

/* tb/bmp_rle_pixel_decoder_tb.sv */
// Testbench top for the BMP RLE pixel decoder: clock, reset, stimulus and verdict.
module bmp_rle_pixel_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmprle_pkg::*;

    localparam logic [REQ_W-1:0]  REQ_UNUSED     = 2'd3;
    localparam logic [BYTE_W-1:0] ESCAPE_LEAD    = 8'd0;
    localparam int                DRAIN_CYCLES   = 4;
    localparam int                WATCHDOG_LIMIT = 500;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [7:0] palette_index, [31:8] palette_color, [39:32] data_byte
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [1:0] req_type
    logic [REQ_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [11:0] x_start, [23:12] row, [31:24] pixel_count,
    // [55:32] color_first, [79:56] color_second
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // image_done
    logic                  m_axis_tlast;

    int   fail_count;
    int   runs_pending;
    int   runs_checked;
    int   done_runs;
    int   items_sent;
    int   quiet_cycles;
    bit   idle_on;
    logic cur_mode;

    bmp_rle_pixel_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bmp_rle_run_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_m_tlast      (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (runs_pending),
        .o_runs_checked (runs_checked),
        .o_done_runs    (done_runs)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stall the result side in random bursts while idling is enabled
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel ||
            !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item, optionally after a gap, and hold it until accepted
    task automatic send_item(input logic [REQ_W-1:0] kind, input logic [7:0] idx,
                             input logic [COLOR_W-1:0] color, input logic [BYTE_W-1:0] data);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {data, color, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] data);
        send_item(REQ_BYTE, $urandom_range(0, 255), $urandom, data);
    endtask

    task automatic send_pal(input logic [7:0] idx, input logic [COLOR_W-1:0] color);
        send_item(REQ_PAL, idx, color, $urandom_range(0, 255));
    endtask

    task automatic send_start();
        send_item(REQ_START, $urandom_range(0, 255), $urandom, $urandom_range(0, 255));
    endtask

    // Drop valid and wait until every run item has come back
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (runs_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] index, input logic [DIM_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {{(APB_DW-DIM_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic mode, input logic [DIM_W-1:0] width,
                             input logic [DIM_W-1:0] height);
        write_reg(REG_MODE, {{(DIM_W-1){1'b0}}, mode});
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
        cur_mode = mode;
    endtask

    // One well-formed bitmap of random commands with a little noise mixed in
    task automatic send_bitmap(input bit quiet);
        int cmds;
        int kind;
        int n;
        int nbytes;
        send_start();
        cmds = $urandom_range(1, 14);
        repeat (cmds) begin
            kind = $urandom_range(0, 19);
            if (kind < 7) begin
                // encoded run, mostly short counts
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) :
                    ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 20);
                send_byte(n);
                send_byte($urandom_range(0, 255));
            end else if (kind < 10) begin
                send_byte(ESCAPE_LEAD);
                send_byte(ESC_EOL);
            end else if (kind < 12) begin
                send_byte(ESCAPE_LEAD);
                send_byte(ESC_DELTA);
                send_byte(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                          $urandom_range(0, 12));
                send_byte(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
                          $urandom_range(0, 2));
            end else if (kind < 16) begin
                // absolute run with its pad byte after an odd byte count
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) :
                    $urandom_range(3, 12);
                nbytes = cur_mode ? (n + 1) / 2 : n;
                send_byte(ESCAPE_LEAD);
                send_byte(n);
                repeat (nbytes) send_byte($urandom_range(0, 255));
                if (nbytes % 2 == 1)
                    send_byte($urandom_range(0, 255));
            end else if (kind < 18) begin
                send_pal((cur_mode && $urandom_range(0, 1)) ? $urandom_range(0, 15) :
                         $urandom_range(0, 255), $urandom);
            end else begin
                case ($urandom_range(0, 2))
                    0: send_byte($urandom_range(0, 255));
                    1: send_item(REQ_UNUSED, $urandom_range(0, 255), $urandom,
                                 $urandom_range(0, 255));
                    default: send_start();
                endcase
            end
        end
        if ($urandom_range(0, 5) != 0) begin
            send_byte(ESCAPE_LEAD);
            send_byte(ESC_EOB);
        end
        idle_on = !quiet && ($urandom_range(0, 3) != 0);
    endtask

    // Reconfigure, refresh the palette and stream random bitmaps
    task automatic run_random(input logic mode, input logic [DIM_W-1:0] width,
                              input logic [DIM_W-1:0] height, input int count, input bit quiet);
        int goal;
        wait_idle();
        configure(mode, width, height);
        for (int k = 0; k < 16; k++)
            send_pal(k, $urandom);
        repeat (4) send_pal($urandom_range(0, 255), $urandom);
        goal = items_sent + count;
        while (items_sent < goal) send_bitmap(quiet);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_START;
        items_sent    = 0;
        quiet_cycles  = 0;
        idle_on       = 1'b1;
        cur_mode      = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 8-bit indices: ignored items, clipping, end of line, delta saturation, top row
        wait_idle();
        configure(1'b0, 13'd16, 13'd2);
        send_byte(8'h01);
        send_item(REQ_UNUSED, 8'hA5, 24'h5A5A5A, 8'h3C);
        send_pal(8'hFF, 24'hFFFFFF);
        send_pal(8'h05, 24'h123456);
        send_start();
        send_byte(8'd20);
        send_byte(8'hFF);
        send_byte(8'd1);
        send_byte(8'h05);
        send_byte(ESCAPE_LEAD);
        send_byte(ESC_EOL);
        send_byte(ESCAPE_LEAD);
        send_byte(ESC_DELTA);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(ESCAPE_LEAD);
        send_byte(ESC_EOL);

        // 4-bit nibbles: odd absolute run with pad, restart mid-image, delta above top
        wait_idle();
        configure(1'b1, 13'd5, 13'd2);
        send_pal(8'h0F, 24'hA5C3E1);
        send_start();
        send_byte(ESCAPE_LEAD);
        send_byte(8'd5);
        send_byte(8'h5F);
        send_byte(8'hF5);
        send_byte(8'h0F);
        send_byte(8'h00);
        send_byte(8'd7);
        send_byte(8'h5F);
        send_byte(8'd4);
        send_start();
        send_byte(ESCAPE_LEAD);
        send_byte(ESC_DELTA);
        send_byte(8'd3);
        send_byte(8'd9);

        // Random bitmaps across register extremes; the last phase runs without idling
        run_random(1'b0, 13'd4096, 13'd4096, 45, 1'b0);
        run_random(1'b1, 13'd1, 13'd1, 40, 1'b0);
        run_random(1'b0, 13'd8191, 13'd0, 40, 1'b0);
        run_random(1'b1, 13'd0, 13'd8191, 35, 1'b0);
        run_random(1'b0, $urandom_range(1, 300), $urandom_range(1, 40), 45, 1'b0);
        idle_on = 1'b0;
        run_random(1'b1, $urandom_range(1, 64), $urandom_range(1, 8), 45, 1'b1);

        wait_idle();
        $display("Sent %0d input items over eight register settings (both depths, width and",
                 items_sent);
        $display("height extremes); checked %0d run items, %0d of them end-of-bitmap.",
                 runs_checked, done_runs);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
